// ===== hdl/rac_pkg.sv =====
package rac_pkg;

  // stream characters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NO_STAR    = 2'd1;
  localparam logic [1:0] ERR_NO_DOLLAR  = 2'd2;
  localparam logic [1:0] ERR_BAD_LENGTH = 2'd3;

  localparam logic [4:0] TOK_LIMIT_RST = 5'd16;

  typedef enum logic [2:0] {
    PH_START,
    PH_DISCARD,
    PH_COUNT,
    PH_DOLLAR,
    PH_LEN,
    PH_PAYLOAD,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic negative;
    logic ended;
    logic started;
    logic saw_cr;
  } num_flags_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] token_index;
    logic       token_last;
    logic [4:0] tok_count;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    logic advance;
    logic process;
  } flow_t;

endpackage

// ===== hdl/rac_in_stage.sv =====
module rac_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          advance_i,
  output rac_pkg::flow_t flow_o,
  output logic [7:0]    byte_o
);
  import rac_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // hold the byte while the result side is stalled
  assign in_stall_o     = valid_q && !advance_i;
  assign load           = in_valid_i && !in_stall_o;
  assign flow_o.advance = advance_i;
  assign flow_o.process = valid_q && advance_i;
  assign byte_o         = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (flow_o.process) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

// ===== hdl/rac_num_line.sv =====
module rac_num_line #(
  parameter int AW  = 17,
  parameter int CAP = 65599
) (
  input  logic [AW-1:0]          accum_i,
  input  rac_pkg::num_flags_t    flags_i,
  input  logic [7:0]             byte_i,
  output logic [AW-1:0]          accum_o,
  output rac_pkg::num_flags_t    flags_o,
  output logic                   line_done_o
);
  import rac_pkg::*;

  logic          digit;
  logic          blank;
  logic [AW+3:0] prod;

  assign digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign blank = byte_i inside {CH_SPACE, [CH_TAB:CH_CR]};
  // accum * 10 + digit value; digits carry their value in the low nibble
  assign prod  = ((AW+4)'(accum_i) << 3) + ((AW+4)'(accum_i) << 1)
               + (AW+4)'(byte_i[3:0]);

  always_comb begin
    accum_o     = accum_i;
    flags_o     = flags_i;
    line_done_o = 1'b0;
    if (flags_i.saw_cr && byte_i == CH_LF) begin
      flags_o.saw_cr = 1'b0;
      line_done_o    = 1'b1;
    end else begin
      flags_o.saw_cr = (byte_i == CH_CR);
      if (!flags_i.ended) begin
        if (!flags_i.started) begin
          if (blank) begin
            flags_o.started = 1'b0;
          end else if (byte_i == CH_PLUS || byte_i == CH_MINUS) begin
            flags_o.started  = 1'b1;
            flags_o.negative = (byte_i == CH_MINUS);
          end else if (digit) begin
            flags_o.started = 1'b1;
            accum_o         = AW'(byte_i[3:0]);
          end else begin
            flags_o.ended = 1'b1;
          end
        end else if (digit) begin
          // saturate so the line value stays bounded
          accum_o = (prod > (AW+4)'(CAP)) ? AW'(CAP) : prod[AW-1:0];
        end else begin
          flags_o.ended = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/rac_parse.sv =====
module rac_parse #(
  parameter int MAX_TOKENS   = 16,
  parameter int MAX_BULK_LEN = 65535
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rac_pkg::flow_t   flow_i,
  input  logic [7:0]       byte_i,
  input  logic [4:0]       tok_limit_i,
  output logic             res_valid_o,
  output rac_pkg::result_t res_o
);
  import rac_pkg::*;

  localparam int CAP = MAX_BULK_LEN + 64;
  localparam int AW  = $clog2(CAP + 1);
  localparam int LW  = $clog2(MAX_BULK_LEN + 1);
  localparam int TW  = $clog2(MAX_TOKENS + 1);
  localparam int EW  = TW + 5;

  phase_e      phase_q, phase_d;
  logic [AW-1:0] accum_q, accum_d;
  num_flags_t  flags_q, flags_d;
  logic [AW-1:0] args_q, args_d;
  logic [TW-1:0] goal_q, goal_d;
  logic [TW-1:0] done_q, done_d;
  logic [LW-1:0] left_q, left_d;
  logic [1:0]  skip_q, skip_d;

  logic [AW-1:0] num_accum;
  num_flags_t  num_flags;
  logic        line_done;
  logic [AW-1:0] args_new;
  logic [AW-1:0] lim;
  logic [AW-1:0] goal_new;
  logic [EW-1:0] done_ext;
  logic        bad_len;
  logic        last_byte;

  rac_num_line #(
    .AW  (AW),
    .CAP (CAP)
  ) u_num (
    .accum_i     (accum_q),
    .flags_i     (flags_q),
    .byte_i      (byte_i),
    .accum_o     (num_accum),
    .flags_o     (num_flags),
    .line_done_o (line_done)
  );

  assign args_new = num_flags.negative ? '0 : num_accum;
  assign lim      = ((AW)'(tok_limit_i) > AW'(MAX_TOKENS)) ? AW'(MAX_TOKENS)
                                                           : AW'(tok_limit_i);
  assign goal_new = (args_new < lim) ? args_new : lim;
  assign done_ext = EW'(done_q);
  assign bad_len  = (num_flags.negative && num_accum != '0)
                  || (num_accum > AW'(MAX_BULK_LEN));
  assign last_byte = (left_q <= LW'(1));

  always_comb begin
    phase_d     = phase_q;
    accum_d     = accum_q;
    flags_d     = flags_q;
    args_d      = args_q;
    goal_d      = goal_q;
    done_d      = done_q;
    left_d      = left_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (flow_i.process) begin
      case (phase_q)
        PH_START, PH_DISCARD: begin
          if (byte_i == CH_STAR) begin
            accum_d = '0;
            flags_d = '0;
            phase_d = PH_COUNT;
          end else if (phase_q == PH_START) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_NO_STAR;
            phase_d          = PH_DISCARD;
          end
        end
        PH_COUNT: begin
          accum_d = num_accum;
          flags_d = num_flags;
          if (line_done) begin
            args_d = args_new;
            goal_d = TW'(goal_new);
            done_d = '0;
            if (goal_new == '0) begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_DONE;
              phase_d     = (args_new != '0) ? PH_DISCARD : PH_START;
            end else begin
              phase_d = PH_DOLLAR;
            end
          end
        end
        PH_DOLLAR: begin
          if (byte_i == CH_DOLLAR) begin
            accum_d = '0;
            flags_d = '0;
            phase_d = PH_LEN;
          end else begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_NO_DOLLAR;
            phase_d          = PH_DISCARD;
          end
        end
        PH_LEN: begin
          accum_d = num_accum;
          flags_d = num_flags;
          if (line_done) begin
            if (bad_len) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_BAD_LENGTH;
              phase_d          = PH_DISCARD;
            end else begin
              skip_d = 2'd2;
              if (num_accum == '0) begin
                res_valid_o       = 1'b1;
                res_o.kind        = KIND_EMPTY;
                res_o.token_index = done_ext[3:0];
                done_d            = done_q + TW'(1);
                phase_d           = PH_SKIP;
              end else begin
                left_d  = LW'(num_accum);
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_BYTE;
          res_o.payload_byte = byte_i;
          res_o.token_index  = done_ext[3:0];
          res_o.token_last   = last_byte;
          if (last_byte) begin
            left_d  = '0;
            done_d  = done_q + TW'(1);
            phase_d = PH_SKIP;
          end else begin
            left_d = left_q - LW'(1);
          end
        end
        PH_SKIP: begin
          if (skip_q > 2'd1) begin
            skip_d = skip_q - 2'd1;
          end else begin
            skip_d = '0;
            if (done_q >= goal_q) begin
              res_valid_o     = 1'b1;
              res_o.kind      = KIND_DONE;
              res_o.tok_count = done_ext[4:0];
              // limit cut the message short: drop the rest silently
              phase_d = (AW'(done_q) < args_q) ? PH_DISCARD : PH_START;
            end else begin
              phase_d = PH_DOLLAR;
            end
          end
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      accum_q <= '0;
      flags_q <= '0;
      args_q  <= '0;
      goal_q  <= '0;
      done_q  <= '0;
      left_q  <= '0;
      skip_q  <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      flags_q <= flags_d;
      args_q  <= args_d;
      goal_q  <= goal_d;
      done_q  <= done_d;
      left_q  <= left_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// ===== hdl/resp_array_command_parser.sv =====
// Parses a request byte stream of arrays of bulk strings, one byte per transfer:
// '*' and an argument count line, then per argument '$', a length line, the
// payload bytes and two trailing bytes that are skipped unchecked. Each payload
// byte comes out tagged with its token index and a last-byte mark, an empty
// token gives one empty-token result, and a done result with the token count
// closes the message; format faults give an error result and the parser then
// drops bytes up to the next '*'. At most one result follows each byte. The
// block takes one byte every cycle unless an output stall backs up into the
// input register; a byte is held in the input register, decoded there against
// the parser state, and its result is registered in the output register.
// Output stall holds the output register and then the input register. The
// token limit is sampled when a count line ends; write it only while the
// block is idle. There is no clearing pass after reset.
module resp_array_command_parser #(
  parameter int MAX_TOKENS   = 16,
  parameter int MAX_BULK_LEN = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  // byte input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  // results
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_byte_o,
  output logic [3:0] token_index_o,
  output logic       token_last_o,
  output logic [4:0] tok_count_o,
  output logic [1:0] error_code_o
);
  import rac_pkg::*;

  logic [4:0] max_tok_q;
  flow_t      flow;
  logic [7:0] cur_byte;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic       advance;

  // the output register can take a new result when empty or being drained
  assign advance = !out_valid_q || !out_stall_i;

  // token limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tok_q <= TOK_LIMIT_RST;
    end else if (cfg_we_i) begin
      max_tok_q <= cfg_wdata_i;
    end
  end

  rac_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .flow_o     (flow),
    .byte_o     (cur_byte)
  );

  rac_parse #(
    .MAX_TOKENS   (MAX_TOKENS),
    .MAX_BULK_LEN (MAX_BULK_LEN)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flow_i       (flow),
    .byte_i       (cur_byte),
    .tok_limit_i  (max_tok_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // output register: its valid flag reloads whenever it advances, empty when the byte gave nothing
  always_comb begin
    out_valid_d = out_valid_q;
    if (flow.advance) begin
      out_valid_d = flow.process && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow.process && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign payload_byte_o = out_q.payload_byte;
  assign token_index_o  = out_q.token_index;
  assign token_last_o   = out_q.token_last;
  assign tok_count_o    = out_q.tok_count;
  assign error_code_o   = out_q.error_code;

endmodule

// ===== hdl/rac_checker.sv =====
module rac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] payload_byte_o,
  input logic [3:0] token_index_o,
  input logic       token_last_o,
  input logic [4:0] tok_count_o,
  input logic [1:0] error_code_o
);
  import rac_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn under stall");

  // a stalled result keeps its kind, payload byte, token index and error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(payload_byte_o)
      && $stable(token_index_o) && $stable(error_code_o))
    else $error("result changed under stall");

  // error code present exactly on error results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match kind");

  // byte fields only on payload results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE |-> payload_byte_o == 8'd0 && !token_last_o)
    else $error("payload fields on a non-payload result");

  // token index only on token results; tok_count has no check here
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DONE || kind_o == KIND_ERROR)
      |-> token_index_o == 4'd0)
    else $error("token index on a message-level result");

endmodule

bind resp_array_command_parser rac_checker u_rac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .payload_byte_o (payload_byte_o),
  .token_index_o  (token_index_o),
  .token_last_o   (token_last_o),
  .tok_count_o    (tok_count_o),
  .error_code_o   (error_code_o)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rac_pkg::*;

  // block parameters as instantiated below
  localparam int TOKEN_LIMIT = 16;
  localparam int BULK_LIMIT = 65535;
  // number lines saturate a little above the largest legal length
  localparam int NUM_CAP = BULK_LIMIT + 64;

  // drain wait for results still in the registers, with margin
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int SEGMENT_BYTES = 220;

  // every input starts at a known value
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] payload_byte_o;
  logic [3:0] token_index_o;
  logic       token_last_o;
  logic [4:0] tok_count_o;
  logic [1:0] error_code_o;

  // idle rates in percent, changed only while the block is drained
  int send_idle_pct = 14;
  int recv_idle_pct = 68;

  // long receiver hold-offs: requested here, counted by the receiver
  int hold_requests = 0;
  int holds_taken;
  int hold_left;

  int failures = 0;

  // bytes waiting for the driver, results waiting for the monitor
  logic [7:0] request_bytes[$];
  result_t    awaited_results[$];

  // parser state of the predictor
  logic [4:0]  token_cap = TOK_LIMIT_RST;
  phase_e      parse_phase = PH_START;
  num_flags_t  num_flags = '0;
  logic [16:0] num_accum = '0;
  logic [16:0] args_declared = '0;
  logic [4:0]  token_goal = '0;
  logic [4:0]  tokens_done = '0;
  logic [15:0] payload_left = '0;
  logic [1:0]  skip_left = '0;

  resp_array_command_parser #(
    .MAX_TOKENS  (TOKEN_LIMIT),
    .MAX_BULK_LEN(BULK_LIMIT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .token_index_o (token_index_o),
    .token_last_o  (token_last_o),
    .tok_count_o   (tok_count_o),
    .error_code_o  (error_code_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic void start_number();
    num_accum = '0;
    num_flags = '0;
  endfunction

  // one byte of a count or length line, high once cr lf closes the line;
  // leading blanks, one sign, digits, then anything up to cr lf is ignored
  function automatic bit number_line_done(input logic [7:0] b);
    bit          digit;
    int unsigned grown;
    digit = (b >= CH_ZERO && b <= CH_NINE);
    if (num_flags.saw_cr && b == CH_LF) begin
      num_flags.saw_cr = 1'b0;
      return 1'b1;
    end
    num_flags.saw_cr = (b == CH_CR);
    if (num_flags.ended) return 1'b0;
    if (!num_flags.started) begin
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return 1'b0;
      if (b == CH_PLUS || b == CH_MINUS) begin
        num_flags.started = 1'b1;
        num_flags.negative = (b == CH_MINUS);
      end else if (digit) begin
        num_flags.started = 1'b1;
        num_accum = 17'(b - CH_ZERO);
      end else begin
        num_flags.ended = 1'b1;
      end
      return 1'b0;
    end
    if (digit) begin
      grown = num_accum * 10 + (b - CH_ZERO);
      num_accum = (grown > NUM_CAP) ? 17'(NUM_CAP) : 17'(grown);
    end else begin
      num_flags.ended = 1'b1;
    end
    return 1'b0;
  endfunction

  // done result; a message cut short by the limit drops its remaining bytes
  function automatic result_t message_done();
    result_t r = '0;
    r.kind = KIND_DONE;
    r.tok_count = tokens_done;
    parse_phase = (tokens_done < args_declared) ? PH_DISCARD : PH_START;
    return r;
  endfunction

  function automatic result_t parse_error(input logic [1:0] code);
    result_t r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    parse_phase = PH_DISCARD;
    return r;
  endfunction

  // advance the parser by one accepted byte and queue what it yields
  task automatic parse_byte(input logic [7:0] b);
    result_t    r;
    bit         emits;
    logic [4:0] lim;
    r = '0;
    emits = 1'b0;
    case (parse_phase)
      PH_START, PH_DISCARD: begin
        if (b == CH_STAR) begin
          start_number();
          parse_phase = PH_COUNT;
        end else if (parse_phase == PH_START) begin
          r = parse_error(ERR_NO_STAR);
          emits = 1'b1;
        end
      end
      PH_COUNT: begin
        if (number_line_done(b)) begin
          args_declared = num_flags.negative ? '0 : num_accum;
          lim = (token_cap > TOKEN_LIMIT) ? 5'(TOKEN_LIMIT) : token_cap;
          token_goal = (args_declared < lim) ? args_declared[4:0] : lim;
          tokens_done = '0;
          if (token_goal == 0) begin
            r = message_done();
            emits = 1'b1;
          end else begin
            parse_phase = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (b == CH_DOLLAR) begin
          start_number();
          parse_phase = PH_LEN;
        end else begin
          r = parse_error(ERR_NO_DOLLAR);
          emits = 1'b1;
        end
      end
      PH_LEN: begin
        if (number_line_done(b)) begin
          if ((num_flags.negative && num_accum != 0) || num_accum > BULK_LIMIT) begin
            r = parse_error(ERR_BAD_LENGTH);
            emits = 1'b1;
          end else begin
            skip_left = 2'd2;
            if (num_accum == 0) begin
              r.kind = KIND_EMPTY;
              r.token_index = tokens_done[3:0];
              emits = 1'b1;
              tokens_done++;
              parse_phase = PH_SKIP;
            end else begin
              payload_left = num_accum[15:0];
              parse_phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        r.kind = KIND_BYTE;
        r.payload_byte = b;
        r.token_index = tokens_done[3:0];
        r.token_last = (payload_left <= 1);
        emits = 1'b1;
        if (r.token_last) begin
          payload_left = '0;
          tokens_done++;
          parse_phase = PH_SKIP;
        end else begin
          payload_left--;
        end
      end
      PH_SKIP: begin
        // the two trailing bytes are not looked at
        if (skip_left > 1) begin
          skip_left--;
        end else begin
          skip_left = '0;
          if (tokens_done >= token_goal) begin
            r = message_done();
            emits = 1'b1;
          end else begin
            parse_phase = PH_DOLLAR;
          end
        end
      end
      default: parse_phase = PH_START;
    endcase
    if (emits) awaited_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  task automatic add_text(input string s, input bit end_line = 1'b1);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
    if (end_line) begin
      request_bytes.push_back(CH_CR);
      request_bytes.push_back(CH_LF);
    end
  endtask

  // decimal line; the messy form adds blanks, sign, leading zeros and a tail
  task automatic add_number(input int value, input bit messy);
    string digits;
    digits = $sformatf("%0d", (value < 0) ? -value : value);
    if (messy) begin
      // space or one of tab, lf, vt, ff
      repeat ($urandom_range(0, 2))
        request_bytes.push_back($urandom_range(0, 1) ? CH_SPACE
                                                     : CH_TAB + 8'($urandom_range(0, 3)));
    end
    if (value < 0) request_bytes.push_back(CH_MINUS);
    else if (messy && $urandom_range(0, 1)) request_bytes.push_back(CH_PLUS);
    if (messy) repeat ($urandom_range(0, 2)) request_bytes.push_back(CH_ZERO);
    add_text(digits, 1'b0);
    if (messy && $urandom_range(0, 1)) begin
      // tail starts with a lower-case letter so the number stays as written
      request_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      repeat ($urandom_range(0, 2)) request_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    add_text("");
  endtask

  // mostly well-formed messages with random content, some broken ones
  task automatic add_random_message();
    int count;
    int tokens;
    int len;
    int pick;
    pick = $urandom_range(0, 99);
    // stray bytes between messages
    if (pick < 6)
      repeat ($urandom_range(1, 6)) request_bytes.push_back(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 8) count = -int'($urandom_range(0, 5));
    else if (pick < 14) count = $urandom_range(17, 70000);
    else if (pick < 80) count = $urandom_range(1, 5);
    else count = $urandom_range(6, 20);
    request_bytes.push_back(CH_STAR);
    add_number(count, $urandom_range(0, 99) < 15);
    tokens = (count < 0) ? 0 : ((count > 18) ? 18 : count);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      // wrong marker now and then, often a star
      if (pick < 3) request_bytes.push_back($urandom_range(0, 1) ? CH_STAR
                                                                 : 8'($urandom_range(0, 255)));
      else request_bytes.push_back(CH_DOLLAR);
      if (pick >= 3 && pick < 6) begin
        len = $urandom_range(0, 1) ? -int'($urandom_range(1, 9))
                                   : int'($urandom_range(BULK_LIMIT + 1, 200000));
      end else if (pick < 25) begin
        len = 0;
      end else if (pick < 90) begin
        len = $urandom_range(1, 8);
      end else begin
        len = $urandom_range(9, 40);
      end
      add_number(len, $urandom_range(0, 99) < 15);
      if (len > 0 && len <= BULK_LIMIT)
        repeat (len) request_bytes.push_back(8'($urandom_range(0, 255)));
      // trailing pair is usually cr lf but never checked
      if ($urandom_range(0, 99) < 80) add_text("");
      else repeat (2) request_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------
  // sequencing
  // ---------------------------------------------------------------------

  // all bytes sent and all results back, then room for silent bytes in flight
  task automatic wait_drained();
    do @(posedge clk_i);
    while (request_bytes.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tok_limit(input logic [4:0] cap);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    token_cap = cap;
  endtask

  // one setting of the limit, then a burst of random messages
  task automatic run_segment(input logic [4:0] cap, input bit hold);
    write_tok_limit(cap);
    @(negedge clk_i);
    while (request_bytes.size() < SEGMENT_BYTES) add_random_message();
    // receiver holds off while the driver keeps offering
    if (hold) hold_requests++;
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, limit still at its reset value
    // one token carrying the extreme byte values
    add_text("*1");
    add_text("$2");
    request_bytes.push_back(8'h00);
    request_bytes.push_back(8'hFF);
    add_text("");
    // negative count, zero count, count line with no digits
    add_text("*-3");
    add_text("*0");
    add_text("*abc");
    // wrong first byte, the rest of the line is dropped
    add_text("x");
    // blank, plus sign and trailing text on the count, then an empty token
    add_text("* +2 zz");
    add_text("$0");
    add_text("");
    // star where a dollar belongs: error, and the star is used up
    add_text("*", 1'b0);
    add_text("1");
    // bad lengths: negative, one past the bound, saturated
    add_text("*1");
    add_text("$-1");
    add_text("*1");
    add_text("$65536");
    add_text("*1");
    add_text("$99999999999");
    // carriage return as a leading blank, minus zero length
    request_bytes.push_back(CH_STAR);
    request_bytes.push_back(CH_CR);
    add_text("1");
    add_text("$-0");
    add_text("");
    wait_drained();

    // sender idles little, receiver a lot
    run_segment(5'd1, 1'b1);
    run_segment(5'd16, 1'b0);

    // the other way round
    send_idle_pct = 68;
    recv_idle_pct = 14;
    run_segment(5'd0, 1'b0);
    run_segment(5'd31, 1'b1);
    run_segment(5'($urandom_range(2, 15)), 1'b0);

    // no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(5'd16, 1'b1);
    run_segment(5'd1, 1'b0);

    if (failures == 0 && awaited_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------
  // driver, receiver and monitor
  // ---------------------------------------------------------------------

  // next byte only once the current transfer is done; a stalled byte holds
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (request_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_byte_i <= request_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // random stall, or a long hold-off when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      holds_taken <= 0;
      hold_left <= 0;
    end else if (holds_taken != hold_requests) begin
      holds_taken <= holds_taken + 1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // input transfers feed the predictor, output transfers are checked in order
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display({"%0t: result with none awaited: kind %0d byte %0d index %0d",
                    " last %0d count %0d error %0d"},
                   $time, kind_o, payload_byte_o, token_index_o, token_last_o,
                   tok_count_o, error_code_o);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("kind", want.kind, kind_o);
          compare_field("payload_byte", want.payload_byte, payload_byte_o);
          compare_field("token_index", want.token_index, token_index_o);
          compare_field("token_last", want.token_last, token_last_o);
          compare_field("tok_count", want.tok_count, tok_count_o);
          compare_field("error_code", want.error_code, error_code_o);
        end
      end
      if (in_valid_i && !in_stall_o) parse_byte(in_byte_i);
    end
  end

endmodule
